// ----- rtl/aes_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES-256 CTR package
// Shared widths, register indexes, the S-box table and round functions.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int DATA_W = 64;
    localparam int BLOCK_W = 128;
    localparam int CNT_W = 32;
    localparam int ADDR_W = 6;
    localparam int NUM_ROUNDS = 14;
    localparam int HALF_DEPTH = 15;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_KEY0 = 3'd0;
    localparam reg_idx_t REG_KEY1 = 3'd1;
    localparam reg_idx_t REG_KEY2 = 3'd2;
    localparam reg_idx_t REG_KEY3 = 3'd3;
    localparam reg_idx_t REG_IV_LO = 3'd4;
    localparam reg_idx_t REG_IV_HI = 3'd5;
    localparam reg_idx_t REG_START = 3'd6;

    typedef logic [7:0] byte_t;
    typedef logic [31:0] word_t;
    typedef logic [BLOCK_W-1:0] block_t;

    localparam byte_t SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_t xtime(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic word_t sub_word(input word_t w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[(c*4+r)*8 +: 8] = SBOX[s[(((c+r)%4)*4+r)*8 +: 8]];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        byte_t a0;
        byte_t a1;
        byte_t a2;
        byte_t a3;
        byte_t all;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[(c*4)*8 +: 8];
            a1 = s[(c*4+1)*8 +: 8];
            a2 = s[(c*4+2)*8 +: 8];
            a3 = s[(c*4+3)*8 +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[(c*4)*8 +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[(c*4+1)*8 +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[(c*4+2)*8 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[(c*4+3)*8 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/aes_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES input channel
// Valid/ready channel carrying one data word per handshake.
// ----------------------------------------------------------------------------
interface aes_in_if;
    import aes_pkg::*;

    logic valid;
    logic ready;
    logic [DATA_W-1:0] data_low;
    logic [DATA_W-1:0] data_high;
    logic first_block;
    logic last_block;

    modport source (output valid, data_low, data_high, first_block, last_block,
                    input ready);
    modport sink (input valid, data_low, data_high, first_block, last_block,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/aes_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES output channel
// Valid/ready channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
interface aes_out_if;
    import aes_pkg::*;

    logic valid;
    logic ready;
    logic [DATA_W-1:0] result_low;
    logic [DATA_W-1:0] result_high;
    logic stream_end;

    modport source (output valid, result_low, result_high, stream_end, input ready);
    modport sink (input valid, result_low, result_high, stream_end, output ready);
endinterface
`default_nettype wire

// ----- rtl/aes256_ctr_encrypt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES-256 counter-mode encryptor
// Key registers, key expansion sequencer, round-key RAMs and round unit.
// ----------------------------------------------------------------------------
// An input word is taken only while the block is idle, so a new word is not
// accepted before the last one has finished its rounds; the shared round unit
// applies one round per cycle, holding the last round while the output register
// still holds an unaccepted result, and the two round-key RAMs each deliver one
// half of the round key per cycle. A word flagged first_block first expands the
// key, one round-key RAM entry per cycle, before its rounds start. A finished
// result waits in the output register while the next word is accepted.
module aes256_ctr_encrypt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    aes_in_if.sink                            in_ch,
    aes_out_if.source                         out_ch,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [aes_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [aes_pkg::DATA_W-1:0]   pwdata,
    output logic      [aes_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);
    import aes_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;

    localparam int RAM_AW = $clog2(HALF_DEPTH);
    localparam logic [4:0] LAST_ENTRY = 5'(2 * HALF_DEPTH - 1);
    localparam logic [3:0] LAST_STEP = 4'(NUM_ROUNDS + 1);

    logic [DATA_W-1:0] key_reg [0:3];
    logic [DATA_W-1:0] iv_lo_reg;
    logic [DATA_W-1:0] iv_hi_reg;
    logic [CNT_W-1:0]  start_reg;
    logic [CNT_W-1:0]  counter_reg;

    logic [1:0]   state_reg;
    logic [3:0]   step_reg;
    logic [4:0]   entry_reg;
    byte_t        rcon_reg;
    word_t        win_reg [0:7];
    block_t       aes_reg;
    block_t       data_reg;
    logic         last_reg;

    logic              out_valid_reg;
    block_t            out_data_reg;
    logic              out_end_reg;

    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic              in_fire;
    logic              out_free;
    logic              round_done;

    word_t             tw;
    word_t             fw;
    word_t             wa;
    word_t             wb;
    logic [DATA_W-1:0] entry_val;
    logic [RAM_AW-1:0] rd_addr;
    logic [DATA_W-1:0] rk_even;
    logic [DATA_W-1:0] rk_odd;
    block_t            rk;
    block_t            aes_next;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_comb
    begin
        unique case (cfg_idx)
            REG_KEY0:  prdata = key_reg[0];
            REG_KEY1:  prdata = key_reg[1];
            REG_KEY2:  prdata = key_reg[2];
            REG_KEY3:  prdata = key_reg[3];
            REG_IV_LO: prdata = iv_lo_reg;
            REG_IV_HI: prdata = iv_hi_reg;
            REG_START: prdata = {{(DATA_W-CNT_W){1'b0}}, start_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
            iv_lo_reg <= '0;
            iv_hi_reg <= '0;
            start_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_KEY0:  key_reg[0] <= pwdata;
                REG_KEY1:  key_reg[1] <= pwdata;
                REG_KEY2:  key_reg[2] <= pwdata;
                REG_KEY3:  key_reg[3] <= pwdata;
                REG_IV_LO: iv_lo_reg <= pwdata;
                REG_IV_HI: iv_hi_reg <= pwdata;
                REG_START: start_reg <= pwdata[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign round_done = (state_reg == ST_ROUND) && (step_reg == LAST_STEP) && out_free;

    always_comb
    begin
        tw = win_reg[7];
        if (entry_reg[1:0] == 2'd0)
        begin
            fw = {SBOX[tw[7:0]], SBOX[tw[31:24]], SBOX[tw[23:16]],
                  SBOX[tw[15:8]] ^ rcon_reg};
        end
        else if (entry_reg[1:0] == 2'd2)
        begin
            fw = sub_word(tw);
        end
        else
        begin
            fw = tw;
        end
        wa = win_reg[0] ^ fw;
        wb = win_reg[1] ^ wa;
        if (entry_reg < 5'd4)
        begin
            entry_val = key_reg[entry_reg[1:0]];
        end
        else
        begin
            entry_val = {wb, wa};
        end
    end

    assign rd_addr = (step_reg == LAST_STEP) ? RAM_AW'(NUM_ROUNDS)
                                             : step_reg[RAM_AW-1:0];

    aes_ram #(.WIDTH(DATA_W), .DEPTH(HALF_DEPTH)) u_ram_even (
        .clk     (clk),
        .wr_en   (state_reg == ST_EXPAND && !entry_reg[0]),
        .wr_addr (entry_reg[4:1]),
        .wr_data (entry_val),
        .rd_addr (rd_addr),
        .rd_data (rk_even)
    );

    aes_ram #(.WIDTH(DATA_W), .DEPTH(HALF_DEPTH)) u_ram_odd (
        .clk     (clk),
        .wr_en   (state_reg == ST_EXPAND && entry_reg[0]),
        .wr_addr (entry_reg[4:1]),
        .wr_data (entry_val),
        .rd_addr (rd_addr),
        .rd_data (rk_odd)
    );

    assign rk = {rk_odd, rk_even};

    always_comb
    begin
        if (step_reg == 4'd1)
        begin
            aes_next = {counter_reg, iv_hi_reg[CNT_W-1:0], iv_lo_reg} ^ rk;
        end
        else if (step_reg == LAST_STEP)
        begin
            aes_next = sub_shift(aes_reg) ^ rk;
        end
        else
        begin
            aes_next = mix_columns(sub_shift(aes_reg)) ^ rk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            entry_reg <= '0;
            counter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (round_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        step_reg <= '0;
                        entry_reg <= '0;
                        state_reg <= in_ch.first_block ? ST_EXPAND : ST_ROUND;
                    end
                end
                ST_EXPAND:
                begin
                    entry_reg <= entry_reg + 5'd1;
                    if (entry_reg == LAST_ENTRY)
                    begin
                        counter_reg <= iv_hi_reg[DATA_W-1:CNT_W] + start_reg;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    if (step_reg != LAST_STEP)
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                    else if (out_free)
                    begin
                        counter_reg <= counter_reg + 32'd1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_reg <= {in_ch.data_high, in_ch.data_low};
            last_reg <= in_ch.last_block;
            rcon_reg <= 8'h01;
            for (int k = 0; k < 4; k++)
            begin
                win_reg[2*k] <= key_reg[k][31:0];
                win_reg[2*k+1] <= key_reg[k][63:32];
            end
        end
        else if (state_reg == ST_EXPAND && entry_reg >= 5'd4)
        begin
            for (int k = 0; k < 6; k++)
            begin
                win_reg[k] <= win_reg[k+2];
            end
            win_reg[6] <= wa;
            win_reg[7] <= wb;
            if (entry_reg[1:0] == 2'd0)
            begin
                rcon_reg <= xtime(rcon_reg);
            end
        end
        if (state_reg == ST_ROUND && step_reg != 4'd0 && step_reg != LAST_STEP)
        begin
            aes_reg <= aes_next;
        end
        if (round_done)
        begin
            out_data_reg <= aes_next ^ data_reg;
            out_end_reg <= last_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.result_low = out_data_reg[DATA_W-1:0];
    assign out_ch.result_high = out_data_reg[BLOCK_W-1:DATA_W];
    assign out_ch.stream_end = out_end_reg;
endmodule
`default_nettype wire

// ----- rtl/aes_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/aes_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// AES-256 CTR port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
module aes_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [aes_pkg::DATA_W-1:0]  result_low,
    input wire logic [aes_pkg::DATA_W-1:0]  result_high,
    input wire logic                        stream_end
);
    import aes_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is still in flight");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && !$past(in_ready))
        else $error("result appeared without the block finishing a word");

    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_low)
            && $stable(result_high) && $stable(stream_end))
        else $error("stalled result word changed");
endmodule

bind aes256_ctr_encrypt aes_checker u_aes_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .result_low  (out_ch.result_low),
    .result_high (out_ch.result_high),
    .stream_end  (out_ch.stream_end)
);
`default_nettype wire

// ----- dv/aes256_ctr_encrypt_tb.sv -----
// ----------------------------------------------------------------------------
// AES-256 CTR encryptor testbench
// Drives random and directed data words through the encryptor with random
// gaps and stalls on both channels, predicts every result with an independent
// AES-256 counter-mode model and compares each field of each result word.
// ----------------------------------------------------------------------------
module aes256_ctr_encrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import aes_pkg::*;

    typedef struct packed {
        logic [63:0] res_lo;
        logic [63:0] res_hi;
        logic        res_end;
    } cipher_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    aes_in_if in_ch();
    aes_out_if out_ch();

    aes256_ctr_encrypt uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    logic [63:0] key_regs [0:3];
    logic [63:0] iv_lo;
    logic [63:0] iv_hi;
    logic [31:0] start_cnt;
    logic [63:0] round_keys [0:29];
    logic [31:0] ctr_value;
    cipher_word_t pending_cipher [$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int streams = 0;
    longint cycles = 0;
    bit stall_enable = 1'b1;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data_low = '0;
        in_ch.data_high = '0;
        in_ch.first_block = 1'b0;
        in_ch.last_block = 1'b0;
        out_ch.ready = 1'b0;
    end

    function automatic byte_t gf2(byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic byte_t gfmul(byte_t a, byte_t b);
        byte_t acc;
        acc = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                acc ^= a;
            a = gf2(a);
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic byte_t sbox_calc(byte_t x);
        byte_t r;
        byte_t p;
        r = 1;
        p = x;
        for (int e = 0; e < 8; e++)
        begin
            if (e != 0)
                r = gfmul(r, p);
            p = gfmul(p, p);
        end
        if (x == 0)
            r = 0;
        return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
            ^ {r[3:0], r[7:4]} ^ 8'h63;
    endfunction

    byte_t sbox_tab [0:255];

    initial
    begin
        for (int i = 0; i < 256; i++)
            sbox_tab[i] = sbox_calc(byte_t'(i));
    end

    function automatic void expand_round_keys();
        byte_t w [0:239];
        byte_t t [0:3];
        byte_t t0;
        byte_t rc;
        rc = 8'h01;
        for (int i = 0; i < 32; i++)
            w[i] = key_regs[i / 8][8 * (i % 8) +: 8];
        for (int i = 8; i < 60; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[(i - 1) * 4 + j];
            if (i % 8 == 0)
            begin
                t0 = t[0];
                t[0] = sbox_tab[t[1]] ^ rc;
                t[1] = sbox_tab[t[2]];
                t[2] = sbox_tab[t[3]];
                t[3] = sbox_tab[t0];
                rc = gf2(rc);
            end
            else if (i % 8 == 4)
            begin
                for (int j = 0; j < 4; j++)
                    t[j] = sbox_tab[t[j]];
            end
            for (int j = 0; j < 4; j++)
                w[i * 4 + j] = w[(i - 8) * 4 + j] ^ t[j];
        end
        for (int i = 0; i < 30; i++)
            for (int j = 0; j < 8; j++)
                round_keys[i][8 * j +: 8] = w[i * 8 + j];
    endfunction

    function automatic logic [127:0] encrypt_counter(logic [127:0] s);
        logic [127:0] t;
        byte_t a [0:3];
        byte_t x;
        s ^= {round_keys[1], round_keys[0]};
        for (int r = 1; r <= 14; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int q = 0; q < 4; q++)
                    t[(c * 4 + q) * 8 +: 8] = sbox_tab[s[(((c + q) % 4) * 4 + q) * 8 +: 8]];
            s = t;
            if (r < 14)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    for (int q = 0; q < 4; q++)
                        a[q] = s[(c * 4 + q) * 8 +: 8];
                    x = a[0] ^ a[1] ^ a[2] ^ a[3];
                    for (int q = 0; q < 4; q++)
                        s[(c * 4 + q) * 8 +: 8] = a[q] ^ x ^ gf2(a[q] ^ a[(q + 1) % 4]);
                end
            end
            s ^= {round_keys[2 * r + 1], round_keys[2 * r]};
        end
        return s;
    endfunction

    function automatic void predict_cipher(logic [63:0] dlo, logic [63:0] dhi,
                                           logic first, logic last);
        logic [127:0] ks;
        cipher_word_t e;
        if (first)
        begin
            expand_round_keys();
            ctr_value = iv_hi[63:32] + start_cnt;
        end
        ks = encrypt_counter({ctr_value, iv_hi[31:0], iv_lo});
        e.res_lo = ks[63:0] ^ dlo;
        e.res_hi = ks[127:64] ^ dhi;
        e.res_end = last;
        pending_cipher.push_back(e);
        ctr_value = ctr_value + 1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("aes256_ctr_encrypt_tb failed");
            $finish;
        end
    end

    int out_wait = 0;

    always @(posedge clk)
    begin
        cipher_word_t e;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                words_checked++;
                if (pending_cipher.size() == 0)
                    report_mismatch("unexpected word", out_ch.result_low, 0);
                else
                begin
                    e = pending_cipher.pop_front();
                    if (out_ch.result_low !== e.res_lo)
                        report_mismatch("result_low", out_ch.result_low, e.res_lo);
                    if (out_ch.result_high !== e.res_hi)
                        report_mismatch("result_high", out_ch.result_high, e.res_hi);
                    if (out_ch.stream_end !== e.res_end)
                        report_mismatch("stream_end", out_ch.stream_end, e.res_end);
                end
                out_wait = stall_enable ? $urandom_range(0, 19) : 0;
            end
            if (out_wait > 0)
            begin
                out_ch.ready <= 1'b0;
                out_wait--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(8 * idx);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KEY0: key_regs[0] = value;
            REG_KEY1: key_regs[1] = value;
            REG_KEY2: key_regs[2] = value;
            REG_KEY3: key_regs[3] = value;
            REG_IV_LO: iv_lo = value;
            REG_IV_HI: iv_hi = value;
            REG_START: start_cnt = value[31:0];
            default: ;
        endcase
    endtask

    task automatic send_word(logic [63:0] dlo, logic [63:0] dhi, logic first, logic last);
        int gap;
        gap = stall_enable ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_low <= dlo;
        in_ch.data_high <= dhi;
        in_ch.first_block <= first;
        in_ch.last_block <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_cipher(dlo, dhi, first, last);
        words_sent++;
        if (first)
            streams++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_cipher.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic program_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                               logic [63:0] k3, logic [63:0] lo, logic [63:0] hi,
                               logic [31:0] sc);
        apb_write(REG_KEY0, k0);
        apb_write(REG_KEY1, k1);
        apb_write(REG_KEY2, k2);
        apb_write(REG_KEY3, k3);
        apb_write(REG_IV_LO, lo);
        apb_write(REG_IV_HI, hi);
        apb_write(REG_START, {32'h0, sc});
    endtask

    task automatic test_zero_and_ones();
        program_all(0, 0, 0, 0, 0, 0, 0);
        send_word(0, 0, 1, 0);
        send_word('1, '1, 0, 1);
        wait_drained();
        program_all('1, '1, '1, '1, '1, '1, '1);
        send_word('1, '1, 1, 0);
        send_word(0, 0, 0, 0);
        send_word(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 0, 1);
        wait_drained();
    endtask

    task automatic test_counter_wrap();
        program_all(rand64(), rand64(), rand64(), rand64(), rand64(),
                    {32'hffff_fffe, $urandom()}, 32'h0);
        for (int i = 0; i < 5; i++)
            send_word(rand64(), rand64(), i == 0, i == 4);
        wait_drained();
        program_all(rand64(), rand64(), rand64(), rand64(), rand64(),
                    {32'h8000_0000, $urandom()}, 32'h7fff_ffff);
        for (int i = 0; i < 3; i++)
            send_word(rand64(), rand64(), i == 0, i == 2);
        wait_drained();
    endtask

    task automatic test_midstream_writes();
        program_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), $urandom());
        send_word(rand64(), rand64(), 1, 0);
        wait_drained();
        apb_write(REG_KEY2, rand64());
        apb_write(REG_IV_LO, rand64());
        apb_write(REG_IV_HI, rand64());
        apb_write(REG_START, {32'h0, $urandom()});
        send_word(rand64(), rand64(), 0, 0);
        send_word(rand64(), rand64(), 0, 1);
        send_word(rand64(), rand64(), 1, 1);
        wait_drained();
    endtask

    task automatic test_random_streams(int total);
        int len;
        int sent;
        sent = 0;
        while (sent < total)
        begin
            program_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), $urandom());
            stall_enable = ($urandom_range(0, 3) != 0);
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
            begin
                send_word(rand64(), rand64(), i == 0 || $urandom_range(0, 30) == 0,
                          i == len - 1 || $urandom_range(0, 20) == 0);
                sent++;
            end
            wait_drained();
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_and_ones();
        test_counter_wrap();
        test_midstream_writes();
        test_random_streams(1150);
        wait_drained();
        $display("Sent %0d data words in %0d streams, checked %0d result words.",
                 words_sent, streams, words_checked);
        $display("Covered all-zero and all-one keys, counter wrap and mid-stream writes.");
        if (errors == 0 && pending_cipher.size() == 0)
            $display("aes256_ctr_encrypt_tb passed");
        else
            $display("aes256_ctr_encrypt_tb failed");
        $finish;
    end
endmodule

// ----- aes256_ctr_encrypt.f -----
rtl/aes_pkg.sv
rtl/aes_in_if.sv
rtl/aes_out_if.sv
rtl/aes_ram.sv
rtl/aes256_ctr_encrypt.sv
rtl/aes_checker.sv
dv/aes256_ctr_encrypt_tb.sv
